// ----- design/itr_pkg.sv -----
// ----------------------------------------------------------------------------
// itr_pkg: shared types and constants for the radix digit converter
// Holds field widths, the controller/datapath command and status bundles,
// and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int DEF_MAX_DIGITS  = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int BASE_WIDTH  = 6;
  localparam int DIGIT_WIDTH = 6;
  localparam int CHAR_WIDTH  = 8;

  // Quotient bits resolved per divider cycle.
  localparam int STEP_BITS = 8;

  localparam logic [BASE_WIDTH-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = 6'd36;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic load;     // capture a new item
    logic step;     // run one divider cycle
    logic prime;    // read the most significant digit
    logic advance;  // move to the next lower digit
  } cmd_t;

  typedef struct packed {
    logic base_bad;   // base of the offered item is out of range
    logic pass_last;  // this divider cycle finishes a digit
    logic div_done;   // no further digit after this one
    logic ptr_zero;   // read pointer is on the least significant digit
  } sts_t;

  function automatic logic [CHAR_WIDTH-1:0] char_of(input logic [DIGIT_WIDTH-1:0] d,
                                                    input logic lower);
    logic [CHAR_WIDTH-1:0] d8;
    d8 = CHAR_WIDTH'(d);
    if (d < DIGIT_WIDTH'(10)) begin
      char_of = CHAR_ZERO + d8;
    end else begin
      char_of = (lower ? CHAR_LOWER : CHAR_UPPER) + d8 - CHAR_WIDTH'(10);
    end
  endfunction

endpackage

// ----- design/itr_ctrl.sv -----
// ----------------------------------------------------------------------------
// itr_ctrl: sequencer for the radix digit converter
// Steps each item through capture, repeated division and digit output.
// ----------------------------------------------------------------------------
module itr_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  itr_pkg::sts_t sts,
  output itr_pkg::cmd_t cmd
);
  import itr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PRIME,
    S_SHOW
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SHOW);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load    = s_tvalid;
      S_DIV:   cmd.step    = 1'b1;
      S_PRIME: cmd.prime   = 1'b1;
      S_SHOW:  cmd.advance = m_tready && !sts.ptr_zero;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= sts.base_bad ? S_SHOW : S_DIV;
          end
        end
        S_DIV: begin
          if (sts.pass_last && sts.div_done) begin
            state <= S_PRIME;
          end
        end
        S_PRIME: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (m_tready && sts.ptr_zero) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/itr_dp.sv -----
// ----------------------------------------------------------------------------
// itr_dp: datapath of the radix digit converter
// Multi-bit restoring divider, digit store and character output.
// ----------------------------------------------------------------------------
module itr_dp #(
  parameter int MAX_DIGITS  = itr_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_WIDTH = itr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [VALUE_WIDTH-1:0]       value,
  input  logic [itr_pkg::BASE_WIDTH-1:0] base,
  input  logic                         lowercase,
  input  itr_pkg::cmd_t                cmd,
  output itr_pkg::sts_t                sts,
  output logic [itr_pkg::CHAR_WIDTH-1:0] digit_char,
  output logic                         last,
  output logic                         bad_base
);
  import itr_pkg::*;

  localparam int PASSES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DW     = PASSES * STEP_BITS;
  localparam int PCW    = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);

  logic [DW-1:0]          quot;
  logic [DIGIT_WIDTH-1:0] rem;
  logic [BASE_WIDTH-1:0]  base_r;
  logic                   lower_r;
  logic                   bad_r;
  logic [PCW-1:0]         pass;
  logic [CW-1:0]          count;
  logic [AW-1:0]          ptr;
  logic [DIGIT_WIDTH-1:0] rd_data;
  logic [DIGIT_WIDTH-1:0] store [MAX_DIGITS];

  logic [DW-1:0]          quot_next;
  logic [DIGIT_WIDTH-1:0] rem_next;
  logic [AW-1:0]          rd_addr;
  logic                   pass_last;

  // One divider cycle: STEP_BITS restoring steps on the narrow remainder.
  always_comb begin
    logic [DIGIT_WIDTH:0] trial;
    logic [DIGIT_WIDTH:0] sub;
    quot_next = quot;
    rem_next  = rem;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial     = {rem_next, quot_next[DW-1]};
      quot_next = {quot_next[DW-2:0], 1'b0};
      sub       = trial - {1'b0, base_r};
      if (trial >= {1'b0, base_r}) begin
        rem_next     = sub[DIGIT_WIDTH-1:0];
        quot_next[0] = 1'b1;
      end else begin
        rem_next = trial[DIGIT_WIDTH-1:0];
      end
    end
  end

  assign pass_last    = (pass == PCW'(PASSES - 1));
  assign sts.pass_last = pass_last;
  assign sts.div_done  = (quot_next == '0) || (count + 1'b1 == CW'(MAX_DIGITS));
  assign sts.ptr_zero  = (ptr == '0);
  assign sts.base_bad  = (base < BASE_MIN) || (base > BASE_MAX);

  assign rd_addr = cmd.prime ? AW'(count - 1'b1) : (ptr - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      quot  <= '0;
      count <= '0;
      pass  <= '0;
      ptr   <= '0;
      bad_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        quot  <= DW'(value);
        count <= '0;
        pass  <= '0;
        ptr   <= '0;
        bad_r <= sts.base_bad;
      end else if (cmd.step) begin
        quot <= quot_next;
        if (pass_last) begin
          pass  <= '0;
          count <= count + 1'b1;
        end else begin
          pass <= pass + 1'b1;
        end
      end
      if (cmd.prime) begin
        ptr <= rd_addr;
      end else if (cmd.advance) begin
        ptr <= rd_addr;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= '0;
      base_r  <= base;
      lower_r <= lowercase;
    end else if (cmd.step) begin
      rem <= pass_last ? '0 : rem_next;
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.step && pass_last) begin
      store[count[AW-1:0]] <= rem_next;
    end
    if (cmd.prime || cmd.advance) begin
      rd_data <= store[rd_addr];
    end
  end

  assign digit_char = bad_r ? CHAR_NONE : char_of(rd_data, lower_r);
  assign last       = (ptr == '0);
  assign bad_base   = bad_r;

endmodule

// ----- design/int_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// int_to_radix_digits: integer to ASCII digit stream in base 2..36
// Converts one unsigned value into its digit characters, most significant
// first, one output beat per character with tlast on the final one.
// ----------------------------------------------------------------------------
// One input beat carries a value (read as an unsigned bit pattern), a base
// and a lowercase flag. The block accepts a beat only when idle and works on
// one item at a time. A restoring divider resolves 8 quotient bits per cycle.
// An item goes through accept, division, a read of the top digit from the
// digit store, then one output beat per cycle while the sink is ready. Zero
// gives the single character '0'. A base outside 2..36 gives one beat with
// tuser set, tlast set and character 0. If MAX_DIGITS is smaller than the
// digit count, only the least significant MAX_DIGITS digits are kept.
// ----------------------------------------------------------------------------
module int_to_radix_digits #(
  parameter int MAX_DIGITS  = itr_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_WIDTH = itr_pkg::DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  // Input stream
  input  logic s_tvalid,
  output logic s_tready,
  // tdata, low bit up: value[VALUE_WIDTH], base[6], lowercase[1], zero pad
  input  logic [((VALUE_WIDTH + itr_pkg::BASE_WIDTH + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  // Output stream
  output logic m_tvalid,
  input  logic m_tready,
  // tdata, low bit up: digit_char[8]
  output logic [itr_pkg::CHAR_WIDTH-1:0] m_tdata,
  // tlast: last character of this conversion
  output logic m_tlast,
  // tuser, low bit up: bad_base[1]
  output logic m_tuser
);
  import itr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [VALUE_WIDTH-1:0] in_value;
  logic [BASE_WIDTH-1:0]  in_base;
  logic                   in_lower;

  // Unpack the input beat.
  assign in_value = s_tdata[VALUE_WIDTH-1:0];
  assign in_base  = s_tdata[VALUE_WIDTH +: BASE_WIDTH];
  assign in_lower = s_tdata[VALUE_WIDTH + BASE_WIDTH];

  // Sequencer: decides when to capture, divide, read and emit.
  itr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Divider, digit store and character mapping. The output character is
  // held in the read register, so it stays put while the sink stalls.
  itr_dp #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (in_value),
    .base       (in_base),
    .lowercase  (in_lower),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (m_tdata),
    .last       (m_tlast),
    .bad_base   (m_tuser)
  );

endmodule

// ----- bench/int_to_radix_digits_test.sv -----
// ----------------------------------------------------------------------------
// int_to_radix_digits_test: stream bench for the radix digit converter
// Sends value/base/lowercase beats with random gaps and checks each digit
// character, tlast and the bad-base flag against a digit predictor kept in
// a small scoreboard. The sink stalls at random too.
// ----------------------------------------------------------------------------
module int_to_radix_digits_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W  = itr_pkg::DEF_VALUE_WIDTH;
  localparam int DIGITS_W = itr_pkg::DEF_MAX_DIGITS;
  localparam int TDATA_W  = ((VALUE_W + itr_pkg::BASE_WIDTH + 1 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 340;
  localparam int TAIL_CYCLES  = 200;  // longer than a base-2 conversion

  // One output beat as the bench expects it.
  typedef struct packed {
    logic [itr_pkg::CHAR_WIDTH-1:0] ch;
    logic                           last;
    logic                           bad;
  } char_beat_t;

  // Predict the character stream of each accepted item, then match output
  // beats against it in order.
  class digit_ledger;
    char_beat_t queued_chars[$];
    int         fails = 0;

    function void note_value(logic [VALUE_W-1:0] value,
                             logic [itr_pkg::BASE_WIDTH-1:0] base, logic lower);
      logic [itr_pkg::DIGIT_WIDTH-1:0] remainders[$];
      logic [VALUE_W-1:0]              quot;
      logic [itr_pkg::DIGIT_WIDTH-1:0] d;
      char_beat_t                      beat;
      if (base < itr_pkg::BASE_MIN || base > itr_pkg::BASE_MAX) begin
        beat = '{itr_pkg::CHAR_NONE, 1'b1, 1'b1};
        queued_chars.push_back(beat);
        return;
      end
      if (value == '0) begin
        beat = '{itr_pkg::CHAR_ZERO, 1'b1, 1'b0};
        queued_chars.push_back(beat);
        return;
      end
      // Remainders come out least significant first.
      quot = value;
      while (quot != '0 && remainders.size() < DIGITS_W) begin
        remainders.push_back(itr_pkg::DIGIT_WIDTH'(quot % VALUE_W'(base)));
        quot = quot / VALUE_W'(base);
      end
      for (int i = remainders.size() - 1; i >= 0; i--) begin
        d = remainders[i];
        if (d < 10) begin
          beat.ch = itr_pkg::CHAR_ZERO + 8'(d);
        end else begin
          beat.ch = (lower ? itr_pkg::CHAR_LOWER : itr_pkg::CHAR_UPPER) + 8'(d) - 8'd10;
        end
        beat.last = (i == 0);
        beat.bad  = 1'b0;
        queued_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [itr_pkg::CHAR_WIDTH-1:0] ch, logic last,
                             logic bad);
      char_beat_t want;
      if (queued_chars.size() == 0) begin
        $display("%0t: unexpected beat char %h last %b bad %b", $time, ch, last, bad);
        fails++;
        return;
      end
      want = queued_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: char expected %h got %h", $time, want.ch, ch);
        fails++;
      end
      if (last !== want.last) begin
        $display("%0t: tlast expected %b got %b", $time, want.last, last);
        fails++;
      end
      if (bad !== want.bad) begin
        $display("%0t: bad_base expected %b got %b", $time, want.bad, bad);
        fails++;
      end
    endfunction

    function int pending();
      return queued_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [itr_pkg::CHAR_WIDTH-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  digit_ledger ledger = new;
  bit          send_steady = 1'b0;  // run the source without gaps
  bit          sink_steady = 1'b0;  // run the sink without stalls

  always #2 clk = ~clk;

  int_to_radix_digits u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offer one beat after a random gap; hold it until the block takes it.
  // tvalid stays high across back-to-back beats, so it is only lowered
  // when a gap follows.
  task automatic send_item(input logic [VALUE_W-1:0] value,
                           input logic [itr_pkg::BASE_WIDTH-1:0] base,
                           input logic lower);
    int gap;
    gap = pick_gap(send_steady);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({lower, base, value});
    do @(posedge clk); while (!s_tready);
    ledger.note_value(value, base, lower);
  endtask

  // Drop tvalid and hold the source until every queued character is out.
  task automatic drain_source();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VALUE_W'($urandom_range(1, 40));
      2: return $urandom_range(0, 1) ? '1 : VALUE_W'(32'h8000_0000);
      default: return VALUE_W'($urandom()) >> $urandom_range(0, VALUE_W - 1);
    endcase
  endfunction

  function automatic logic [itr_pkg::BASE_WIDTH-1:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 6'($urandom_range(0, 1));
    if (r < 10) return 6'($urandom_range(37, 63));
    if (r < 14) return 6'd2;
    if (r < 18) return 6'd10;
    if (r < 22) return 6'd16;
    if (r < 26) return 6'd36;
    return 6'($urandom_range(2, 36));
  endfunction

  // Sink: one tready decision per falling edge, with stalls of random length.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap(sink_steady);
      end
      if ($urandom_range(0, 39) == 0) sink_steady = ~sink_steady;
    end
  end

  // Check every accepted output beat at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      ledger.check_char(m_tdata, m_tlast, m_tuser);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, both ends of the base range, out-of-range bases,
    // widest digit strings, letter case, a negative bit pattern.
    send_item(32'd0, 6'd10, 1'b0);
    send_item(32'd0, 6'd2, 1'b1);
    send_item(32'd0, 6'd36, 1'b0);
    send_item(32'd1, 6'd2, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd2, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd36, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd36, 1'b1);
    send_item(32'hFFFF_FFFF, 6'd16, 1'b1);
    send_item(32'hDEAD_BEEF, 6'd16, 1'b0);
    send_item(32'h8000_0000, 6'd10, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd10, 1'b1);
    send_item(32'd35, 6'd36, 1'b0);
    send_item(32'd35, 6'd36, 1'b1);
    send_item(32'd36, 6'd36, 1'b0);
    send_item(32'd12345, 6'd3, 1'b0);
    send_item(32'd7, 6'd35, 1'b1);
    send_item(32'd123456789, 6'd8, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd0, 1'b1);
    send_item(32'd5, 6'd1, 1'b0);
    send_item(32'd0, 6'd37, 1'b1);
    send_item(32'h00AB_CDEF, 6'd63, 1'b0);
    drain_source();

    // Random: mostly valid bases, a share of bad ones, varied digit counts.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0) send_steady = ~send_steady;
      send_item(pick_value(), pick_base(), 1'($urandom_range(0, 1)));
      if (n % 60 == 59) drain_source();
    end
    drain_source();

    // Let any trailing beat show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.fails == 0 && ledger.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
design/itr_pkg.sv
design/itr_ctrl.sv
design/itr_dp.sv
design/int_to_radix_digits.sv
bench/int_to_radix_digits_test.sv
